// ----- rtl/core/wireless_frame_flood_detector_top_defines.svh -----
// assertion macros for the wireless frame flood detector
// no dependencies, included by the top level only
`ifndef WIRELESS_FRAME_FLOOD_DETECTOR_TOP_DEFINES_SVH
`define WIRELESS_FRAME_FLOOD_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WFFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WFFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define WFFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/wffd_pkg.sv -----
// shared types, constants and helpers of the wireless frame flood detector
// no dependencies
package wffd_pkg;

    localparam logic [11:0] MIN_FRAME    = 12'd24;
    localparam logic [7:0]  TYPE_MASK    = 8'h0C;
    localparam logic [7:0]  SUBTYPE_MASK = 8'hF0;
    localparam logic [3:0]  SUB_BEACON   = 4'd8;
    localparam logic [3:0]  SUB_DEAUTH   = 4'd12;
    localparam logic [15:0] SAT16        = 16'hFFFF;

    localparam logic [7:0]  SIG_LOW [4] = '{8'hC0, 8'hA0, 8'h80, 8'h40};
    localparam logic [11:0] SIG_MIN [4] = '{12'd24, 12'd24, 12'd64, 12'd24};
    localparam logic [3:0]  SIG_SEV [4] = '{4'd8, 4'd7, 4'd5, 4'd4};
    localparam logic [7:0]  SIG_HIGH    = 8'h00;
    localparam logic [11:0] SIG_MAX     = 12'd1500;

    localparam logic [1:0] CFG_DEAUTH_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BEACON_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DET_EN       = 2'd2;
    localparam logic [1:0] CFG_SIG_EN       = 2'd3;

    localparam logic [15:0] RST_DEAUTH_LIMIT = 16'd10;
    localparam logic [15:0] RST_BEACON_LIMIT = 16'd50;
    localparam logic [1:0]  RST_DET_EN       = 2'd3;
    localparam logic [3:0]  RST_SIG_EN       = 4'd3;

    typedef struct packed {
        logic        tracked;
        logic        untracked;
        logic [15:0] count;
    } t_tbl_rsp;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
        logic [3:0] sev;
    } t_sig_rsp;

    typedef struct packed {
        logic        frame_accepted;
        logic        deauth_alert;
        logic [15:0] deauth_count;
        logic        untracked_source;
        logic        beacon_alert;
        logic [15:0] beacon_total;
        logic        signature_hit;
        logic [1:0]  signature_index;
        logic [3:0]  signature_severity;
        logic [31:0] frames_seen;
    } t_result;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == SAT16) ? v : v + 16'd1;
    endfunction

endpackage

// ----- rtl/core/wffd_sig_match.sv -----
// signature matcher: first enabled fixed signature hit for one frame
// depends on wffd_pkg
module wffd_sig_match (
    input  logic [3:0]          i_enables,
    input  logic [7:0]          i_control_low,
    input  logic [7:0]          i_control_high,
    input  logic [11:0]         i_frame_length,
    output wffd_pkg::t_sig_rsp  o_rsp
);
    import wffd_pkg::*;

    always_comb begin
        o_rsp = '0;
        for (int k = 3; k >= 0; k--) begin
            if (i_enables[k] && (i_control_low == SIG_LOW[k]) &&
                (i_control_high == SIG_HIGH) && (i_frame_length >= SIG_MIN[k]) &&
                (i_frame_length <= SIG_MAX)) begin
                o_rsp.hit = 1'b1;
                o_rsp.idx = 2'(k);
                o_rsp.sev = SIG_SEV[k];
            end
        end
    end

endmodule

// ----- rtl/core/wffd_src_table.sv -----
// source address table with a sequential scan, one address compare per cycle
// depends on wffd_pkg
module wffd_src_table #(
    parameter  int ENTRIES = 16,
    localparam int IDX_W   = $clog2(ENTRIES),
    localparam int PTR_W   = $clog2(ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_clear,
    input  logic [47:0]        i_src,
    output logic               o_busy,
    output logic               o_done,
    output wffd_pkg::t_tbl_rsp o_rsp
);
    import wffd_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE   = 3'b001,
        T_SCAN   = 3'b010,
        T_UPDATE = 3'b100
    } t_tbl_state;

    logic [47:0] r_addr_mem [ENTRIES];
    logic [15:0] r_cnt_mem  [ENTRIES];

    t_tbl_state         r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_cmp_en, n_cmp_en;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic               r_hit_found, n_hit_found;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [15:0]        r_hit_cnt, n_hit_cnt;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [47:0]        r_src, n_src;
    logic               r_done, n_done;
    t_tbl_rsp           r_rsp, n_rsp;
    logic [47:0]        r_rd_addr;
    logic [15:0]        r_rd_cnt;

    logic        w_issue;
    logic        w_match;
    logic        w_free;
    logic [15:0] w_inc;

    assign w_issue = (r_state == T_SCAN) && (r_ptr != PTR_W'(ENTRIES));
    assign w_match = r_cmp_en && r_valid[r_cmp_idx] && (r_rd_addr == r_src);
    assign w_free  = r_cmp_en && !r_valid[r_cmp_idx];
    assign w_inc   = sat_inc16(r_hit_cnt);

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_addr <= r_addr_mem[r_ptr[IDX_W-1:0]];
            r_rd_cnt  <= r_cnt_mem[r_ptr[IDX_W-1:0]];
        end
        if (r_state == T_UPDATE) begin
            if (r_hit_found) begin
                r_cnt_mem[r_hit_idx] <= w_inc;
            end else if (r_free_found) begin
                r_addr_mem[r_free_idx] <= r_src;
                r_cnt_mem[r_free_idx]  <= 16'd1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_ptr        = r_ptr;
        n_cmp_en     = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_cnt    = r_hit_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_src        = r_src;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        if (i_clear) begin
            n_valid = '0;
        end
        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    n_src        = i_src;
                    n_ptr        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = T_SCAN;
                end
            end
            T_SCAN: begin
                if (w_match && !r_hit_found) begin
                    n_hit_found = 1'b1;
                    n_hit_idx   = r_cmp_idx;
                    n_hit_cnt   = r_rd_cnt;
                end
                if (w_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (w_issue) begin
                    n_ptr     = r_ptr + PTR_W'(1);
                    n_cmp_en  = 1'b1;
                    n_cmp_idx = r_ptr[IDX_W-1:0];
                end else if (!r_cmp_en) begin
                    n_state = T_UPDATE;
                end
            end
            T_UPDATE: begin
                n_rsp.tracked   = r_hit_found || r_free_found;
                n_rsp.untracked = !(r_hit_found || r_free_found);
                if (r_hit_found) begin
                    n_rsp.count = w_inc;
                end else if (r_free_found) begin
                    n_rsp.count             = 16'd1;
                    n_valid[r_free_idx]     = 1'b1;
                end else begin
                    n_rsp.count = '0;
                end
                n_done  = 1'b1;
                n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_valid  <= '0;
            r_cmp_en <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_cmp_en <= n_cmp_en;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_cnt    <= n_hit_cnt;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_src        <= n_src;
        r_rsp        <= n_rsp;
    end

    assign o_busy = (r_state != T_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- rtl/core/wireless_frame_flood_detector_top.sv -----
// top level of the wireless frame flood detector: request handshake, beacon
// window, frame counter, configuration and result register
// depends on wffd_pkg, wffd_src_table, wffd_sig_match and the defines header
//
// One request is taken at a time. A counted deauthentication frame scans the
// source table one entry per cycle through a single address comparator before
// its result is formed. The result sits in an output register, so a new
// request is taken while the previous result waits. Valid bits live in
// flip-flops, so the block is ready straight after reset with no clearing pass.
`include "wireless_frame_flood_detector_top_defines.svh"

module wireless_frame_flood_detector_top #(
    parameter int SOURCE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_control_low,
    input  logic [7:0]  i_control_high,
    input  logic [11:0] i_frame_length,
    input  logic [47:0] i_source_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_accepted,
    output logic        o_deauth_alert,
    output logic [15:0] o_deauth_count,
    output logic        o_untracked_source,
    output logic        o_beacon_alert,
    output logic [15:0] o_beacon_total,
    output logic        o_signature_hit,
    output logic [1:0]  o_signature_index,
    output logic [3:0]  o_signature_severity,
    output logic [31:0] o_frames_seen
);
    import wffd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } t_top_state;

    t_top_state  r_state, n_state;
    logic [15:0] r_deauth_limit;
    logic [15:0] r_beacon_limit;
    logic [1:0]  r_det_en;
    logic [3:0]  r_sig_en;
    logic        r_cmd;
    logic [7:0]  r_cl;
    logic [7:0]  r_ch;
    logic [11:0] r_len;
    logic        r_deauth, n_deauth;
    logic [15:0] r_bcn, n_bcn;
    logic [31:0] r_frames, n_frames;
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    logic        w_accept;
    logic        w_in_deauth;
    logic        w_load;
    logic        w_tbl_clear;
    logic        w_tbl_busy;
    logic        w_tbl_done;
    t_tbl_rsp    w_tbl_rsp;
    t_sig_rsp    w_sig;
    logic        w_acc;
    logic        w_beacon;
    logic [15:0] w_bcn_next;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_deauth = !i_cmd && (i_frame_length >= MIN_FRAME) &&
                         ((i_control_low & TYPE_MASK) == 8'h00) &&
                         (i_control_low[7:4] == SUB_DEAUTH) && r_det_en[0];
    assign w_load      = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);
    assign w_tbl_clear = w_load && r_cmd;

    wffd_src_table #(
        .ENTRIES (SOURCE_ENTRIES)
    ) u_src_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_in_deauth),
        .i_clear (w_tbl_clear),
        .i_src   (i_source_address),
        .o_busy  (w_tbl_busy),
        .o_done  (w_tbl_done),
        .o_rsp   (w_tbl_rsp)
    );

    wffd_sig_match u_sig_match (
        .i_enables      (r_sig_en),
        .i_control_low  (r_cl),
        .i_control_high (r_ch),
        .i_frame_length (r_len),
        .o_rsp          (w_sig)
    );

    assign w_acc      = !r_cmd && (r_len >= MIN_FRAME);
    assign w_beacon   = w_acc && ((r_cl & TYPE_MASK) == 8'h00) &&
                        (((r_cl & SUBTYPE_MASK) >> 4) == 8'(SUB_BEACON)) && r_det_en[1];
    assign w_bcn_next = w_beacon ? sat_inc16(r_bcn) : r_bcn;

    always_comb begin
        n_state     = r_state;
        n_deauth    = r_deauth;
        n_bcn       = r_bcn;
        n_frames    = r_frames;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_deauth = w_in_deauth;
                    n_state  = w_in_deauth ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (w_tbl_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_load) begin
                    n_res = '0;
                    if (r_cmd) begin
                        n_bcn = '0;
                    end else begin
                        n_frames = r_frames + 32'd1;
                        n_bcn    = w_bcn_next;
                        if (w_acc) begin
                            n_res.frame_accepted = 1'b1;
                            n_res.beacon_total   = w_bcn_next;
                            n_res.beacon_alert   = w_beacon && (w_bcn_next > r_beacon_limit);
                            if (r_deauth) begin
                                n_res.untracked_source = w_tbl_rsp.untracked;
                                if (w_tbl_rsp.tracked) begin
                                    n_res.deauth_count = w_tbl_rsp.count;
                                    n_res.deauth_alert = w_tbl_rsp.count > r_deauth_limit;
                                end
                            end
                            n_res.signature_hit      = w_sig.hit;
                            n_res.signature_index    = w_sig.idx;
                            n_res.signature_severity = w_sig.sev;
                        end
                    end
                    n_res.frames_seen = n_frames;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_deauth_limit <= RST_DEAUTH_LIMIT;
            r_beacon_limit <= RST_BEACON_LIMIT;
            r_det_en       <= RST_DET_EN;
            r_sig_en       <= RST_SIG_EN;
            r_deauth       <= 1'b0;
            r_bcn          <= '0;
            r_frames       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_deauth    <= n_deauth;
            r_bcn       <= n_bcn;
            r_frames    <= n_frames;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEAUTH_LIMIT: r_deauth_limit <= i_cfg_data;
                    CFG_BEACON_LIMIT: r_beacon_limit <= i_cfg_data;
                    CFG_DET_EN:       r_det_en       <= i_cfg_data[1:0];
                    CFG_SIG_EN:       r_sig_en       <= i_cfg_data[3:0];
                    default:          r_det_en       <= r_det_en;
                endcase
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_cl  <= i_control_low;
            r_ch  <= i_control_high;
            r_len <= i_frame_length;
        end
        r_res <= n_res;
    end

    assign o_out_valid          = r_out_valid;
    assign o_frame_accepted     = r_res.frame_accepted;
    assign o_deauth_alert       = r_res.deauth_alert;
    assign o_deauth_count       = r_res.deauth_count;
    assign o_untracked_source   = r_res.untracked_source;
    assign o_beacon_alert       = r_res.beacon_alert;
    assign o_beacon_total       = r_res.beacon_total;
    assign o_signature_hit      = r_res.signature_hit;
    assign o_signature_index    = r_res.signature_index;
    assign o_signature_severity = r_res.signature_severity;
    assign o_frames_seen        = r_res.frames_seen;

    `WFFD_ASSERT_IMPLIES(a_done_in_scan, i_clk, i_rst_n, w_tbl_done, r_state == S_SCAN, "table done outside scan")
    `WFFD_ASSERT_IMPLIES(a_rsp_exclusive, i_clk, i_rst_n, w_tbl_done, w_tbl_rsp.tracked != w_tbl_rsp.untracked, "table response both or neither")
    `WFFD_ASSERT_IMPLIES(a_ready_table_idle, i_clk, i_rst_n, o_in_ready, !w_tbl_busy, "ready while table scans")
    `WFFD_ASSERT_NEXT(a_frame_count, i_clk, i_rst_n, w_load && !r_cmd, r_frames == $past(r_frames) + 32'd1, "frame counter missed a frame")

endmodule

// ----- test/wireless_frame_flood_detector_top_test.sv -----
// self-checking testbench for wireless_frame_flood_detector_top: directed table, then
// random frame and clear requests under varied register settings and idling, with a
// behavioural predictor; depends on wffd_pkg and the detector rtl
module wireless_frame_flood_detector_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wffd_pkg::*;

    localparam int          SRC_ENTRIES   = 16;
    localparam int          POOL_SIZE     = 20;
    localparam int          DIRECTED_ROWS = 22;
    localparam int          PHASE_ITEMS   = 162;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          MAX_REPORTS   = 10;
    localparam bit          CMD_FRAME     = 1'b0;
    localparam bit          CMD_CLEAR     = 1'b1;
    localparam logic [7:0]  FC_DEAUTH     = 8'hC0;
    localparam logic [7:0]  FC_DISASSOC   = 8'hA0;
    localparam logic [7:0]  FC_BEACON     = 8'h80;
    localparam logic [7:0]  FC_PROBE      = 8'h40;
    localparam logic [47:0] ADDR_ONES     = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        bit          cmd;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [11:0] len;
        logic [47:0] addr;
        bit          typed;
        t_result     want;
    } t_stim_row;

    typedef struct {
        logic [15:0] deauth_limit;
        logic [15:0] beacon_limit;
        logic [15:0] det_data;
        logic [15:0] sig_data;
    } t_reg_setting;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_idx        = CFG_DEAUTH_LIMIT;
    logic [15:0] i_cfg_data       = 16'd0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic        i_cmd            = CMD_FRAME;
    logic [7:0]  i_control_low    = 8'd0;
    logic [7:0]  i_control_high   = 8'd0;
    logic [11:0] i_frame_length   = 12'd0;
    logic [47:0] i_source_address = 48'd0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic        o_frame_accepted;
    logic        o_deauth_alert;
    logic [15:0] o_deauth_count;
    logic        o_untracked_source;
    logic        o_beacon_alert;
    logic [15:0] o_beacon_total;
    logic        o_signature_hit;
    logic [1:0]  o_signature_index;
    logic [3:0]  o_signature_severity;
    logic [31:0] o_frames_seen;

    // predictor state and register shadows
    logic [47:0]            tracked_addr    [SRC_ENTRIES];
    logic [15:0]            tracked_deauths [SRC_ENTRIES];
    bit [SRC_ENTRIES-1:0]   tracked_used     = '0;
    logic [15:0]            window_beacons   = '0;
    logic [31:0]            frame_tally      = '0;
    logic [15:0]            deauth_limit_reg = RST_DEAUTH_LIMIT;
    logic [15:0]            beacon_limit_reg = RST_BEACON_LIMIT;
    logic [1:0]             detector_en_reg  = RST_DET_EN;
    logic [3:0]             signature_en_reg = RST_SIG_EN;

    t_result     pending_verdicts [$];
    logic [47:0] addr_pool [POOL_SIZE];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          requests_sent  = 0;
    int          results_seen   = 0;
    int          settings_used  = 0;
    int          deauth_alerts  = 0;
    int          beacon_alerts  = 0;
    int          untracked_seen = 0;
    int          signature_hits = 0;

    t_reg_setting reg_settings [8];

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd23, ADDR_ONES, 1'b1,
          {1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 2'd0, 4'd0, 32'd1}},
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd24, ADDR_ONES, 1'b1,
          {1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 16'd0, 1'b1, 2'd0, 4'd8, 32'd2}},
        '{CMD_FRAME, FC_DISASSOC, 8'h00, 12'd1500, 48'd0, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 2'd1, 4'd7, 32'd3}},
        '{CMD_FRAME, FC_DISASSOC, 8'h00, 12'd1501, 48'd0, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 2'd0, 4'd0, 32'd4}},
        '{CMD_FRAME, FC_BEACON, 8'h00, 12'd63, 48'd0, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd1, 1'b0, 2'd0, 4'd0, 32'd5}},
        '{CMD_FRAME, FC_PROBE, 8'h00, 12'd4095, 48'd0, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd1, 1'b0, 2'd0, 4'd0, 32'd6}},
        '{CMD_FRAME, FC_DEAUTH, 8'hFF, 12'd24, ADDR_ONES, 1'b1,
          {1'b1, 1'b0, 16'd2, 1'b0, 1'b0, 16'd1, 1'b0, 2'd0, 4'd0, 32'd7}},
        '{CMD_FRAME, 8'hC4, 8'h00, 12'd100, 48'd0, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd1, 1'b0, 2'd0, 4'd0, 32'd8}},
        '{CMD_FRAME, 8'hFF, 8'hFF, 12'd4095, ADDR_ONES, 1'b1,
          {1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd1, 1'b0, 2'd0, 4'd0, 32'd9}},
        '{CMD_CLEAR, 8'hFF, 8'hFF, 12'd4095, ADDR_ONES, 1'b1,
          {1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 2'd0, 4'd0, 32'd9}},
        '{CMD_FRAME, 8'hC3, 8'h00, 12'd24, ADDR_ONES, 1'b1,
          {1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 16'd0, 1'b0, 2'd0, 4'd0, 32'd10}},
        '{CMD_FRAME, 8'h00, 8'h00, 12'd0, 48'd0, 1'b1,
          {1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 2'd0, 4'd0, 32'd11}},
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd24, 48'h0000_0000_0001, 1'b0, '0},
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd1500, 48'h8000_0000_0000, 1'b0, '0},
        '{CMD_FRAME, FC_BEACON, 8'h00, 12'd64, 48'd0, 1'b0, '0},
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd24, ADDR_ONES, 1'b0, '0},
        '{CMD_FRAME, 8'hC1, 8'h55, 12'd2048, 48'h5555_5555_5555, 1'b0, '0},
        '{CMD_FRAME, 8'hC2, 8'hAA, 12'd24, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
        '{CMD_FRAME, FC_BEACON, 8'h01, 12'd4095, 48'h1234_5678_9ABC, 1'b0, '0},
        '{CMD_CLEAR, 8'h00, 8'h00, 12'd0, 48'd0, 1'b0, '0},
        '{CMD_FRAME, 8'h88, 8'h00, 12'd30, 48'd0, 1'b0, '0},
        '{CMD_FRAME, FC_DEAUTH, 8'h00, 12'd24, 48'h5555_5555_5555, 1'b0, '0}
    };

    wireless_frame_flood_detector_top #(
        .SOURCE_ENTRIES(SRC_ENTRIES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_control_low       (i_control_low),
        .i_control_high      (i_control_high),
        .i_frame_length      (i_frame_length),
        .i_source_address    (i_source_address),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_frame_accepted    (o_frame_accepted),
        .o_deauth_alert      (o_deauth_alert),
        .o_deauth_count      (o_deauth_count),
        .o_untracked_source  (o_untracked_source),
        .o_beacon_alert      (o_beacon_alert),
        .o_beacon_total      (o_beacon_total),
        .o_signature_hit     (o_signature_hit),
        .o_signature_index   (o_signature_index),
        .o_signature_severity(o_signature_severity),
        .o_frames_seen       (o_frames_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result score_frame(input bit cmd, input logic [7:0] fc_low,
                                            input logic [7:0] fc_high,
                                            input logic [11:0] len, input logic [47:0] addr);
        t_result v;
        int      slot;
        int      spare;
        v = '0;
        if (cmd == CMD_CLEAR) begin
            tracked_used   = '0;
            window_beacons = '0;
        end else begin
            frame_tally = frame_tally + 32'd1;
            if (len >= MIN_FRAME) begin
                v.frame_accepted = 1'b1;
                if ((fc_low & TYPE_MASK) == 8'd0) begin
                    if (fc_low[7:4] == SUB_DEAUTH && detector_en_reg[0]) begin
                        slot  = -1;
                        spare = -1;
                        for (int i = 0; i < SRC_ENTRIES; i++) begin
                            if (tracked_used[i]) begin
                                if (slot < 0 && tracked_addr[i] == addr) slot = i;
                            end else if (spare < 0) begin
                                spare = i;
                            end
                        end
                        if (slot >= 0) begin
                            if (tracked_deauths[slot] != 16'hFFFF)
                                tracked_deauths[slot] = tracked_deauths[slot] + 16'd1;
                        end else if (spare >= 0) begin
                            slot                  = spare;
                            tracked_used[slot]    = 1'b1;
                            tracked_addr[slot]    = addr;
                            tracked_deauths[slot] = 16'd1;
                        end
                        if (slot >= 0) begin
                            v.deauth_count = tracked_deauths[slot];
                            v.deauth_alert = tracked_deauths[slot] > deauth_limit_reg;
                        end else begin
                            v.untracked_source = 1'b1;
                        end
                    end else if (fc_low[7:4] == SUB_BEACON && detector_en_reg[1]) begin
                        if (window_beacons != 16'hFFFF) window_beacons = window_beacons + 16'd1;
                        v.beacon_alert = window_beacons > beacon_limit_reg;
                    end
                end
                v.beacon_total = window_beacons;
                for (int i = 0; i < 4; i++) begin
                    if (!v.signature_hit && signature_en_reg[i] && fc_low == SIG_LOW[i] &&
                        fc_high == SIG_HIGH && len >= SIG_MIN[i] && len <= SIG_MAX) begin
                        v.signature_hit      = 1'b1;
                        v.signature_index    = 2'(i);
                        v.signature_severity = SIG_SEV[i];
                    end
                end
            end
        end
        v.frames_seen = frame_tally;
        return v;
    endfunction

    task automatic send_request(input bit cmd, input logic [7:0] lo, input logic [7:0] hi,
                                input logic [11:0] len, input logic [47:0] addr,
                                input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_control_low    <= lo;
        i_control_high   <= hi;
        i_frame_length   <= len;
        i_source_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = score_frame(cmd, lo, hi, len, addr);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic send_random_request();
        bit          cmd;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [11:0] len;
        logic [47:0] addr;
        int          kind;
        kind = $urandom_range(99);
        cmd  = CMD_FRAME;
        lo   = 8'($urandom);
        hi   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        len  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1600, 24));
        addr = ($urandom_range(9) < 3) ? addr_pool[$urandom_range(2)]
                                       : addr_pool[$urandom_range(POOL_SIZE - 1)];
        if (kind < 2) begin
            cmd = CMD_CLEAR;
        end else if (kind < 8) begin
            len = 12'($urandom_range(23));
        end else if (kind < 45) begin
            lo = FC_DEAUTH | (($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'h00);
        end else if (kind < 70) begin
            lo = FC_BEACON | (($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'h00);
            if ($urandom_range(1) == 1) len = 12'($urandom_range(140, 24));
        end else if (kind < 80) begin
            lo = ($urandom_range(1) == 1) ? FC_DISASSOC : FC_PROBE;
        end else begin
            hi   = 8'($urandom);
            len  = 12'($urandom);
            addr = 48'({$urandom, $urandom});
        end
        send_request(cmd, lo, hi, len, addr, 1'b0, '0);
    endtask

    task automatic drain_pending();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic apply_settings(input t_reg_setting s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEAUTH_LIMIT;
        i_cfg_data <= s.deauth_limit;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BEACON_LIMIT;
        i_cfg_data <= s.beacon_limit;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DET_EN;
        i_cfg_data <= s.det_data;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SIG_EN;
        i_cfg_data <= s.sig_data;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        deauth_limit_reg = s.deauth_limit;
        beacon_limit_reg = s.beacon_limit;
        detector_en_reg  = s.det_data[1:0];
        signature_en_reg = s.sig_data[3:0];
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s after %0d results: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        t_result got;
        got = {o_frame_accepted, o_deauth_alert, o_deauth_count, o_untracked_source,
               o_beacon_alert, o_beacon_total, o_signature_hit, o_signature_index,
               o_signature_severity, o_frames_seen};
        if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result with no request outstanding: %h", got);
        end else begin
            want = pending_verdicts.pop_front();
            results_seen++;
            compare_field("frame_accepted", want.frame_accepted, got.frame_accepted);
            compare_field("deauth_alert", want.deauth_alert, got.deauth_alert);
            compare_field("deauth_count", want.deauth_count, got.deauth_count);
            compare_field("untracked_source", want.untracked_source, got.untracked_source);
            compare_field("beacon_alert", want.beacon_alert, got.beacon_alert);
            compare_field("beacon_total", want.beacon_total, got.beacon_total);
            compare_field("signature_hit", want.signature_hit, got.signature_hit);
            compare_field("signature_index", want.signature_index, got.signature_index);
            compare_field("signature_severity", want.signature_severity,
                          got.signature_severity);
            compare_field("frames_seen", want.frames_seen, got.frames_seen);
            deauth_alerts  += int'(got.deauth_alert);
            beacon_alerts  += int'(got.beacon_alert);
            untracked_seen += int'(got.untracked_source);
            signature_hits += int'(got.signature_hit);
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) check_result();
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int           send_modes [4];
        int           recv_modes [4];
        send_modes = '{0, 86, 0, 12};
        recv_modes = '{0, 0, 86, 12};
        foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
        addr_pool[0] = 48'd0;
        addr_pool[1] = ADDR_ONES;
        reg_settings[0] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
        reg_settings[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFF0};
        reg_settings[2] = '{16'd3, 16'd20, 16'h0001, 16'h000A};
        reg_settings[3] = '{16'd1, 16'd5, 16'h0000, 16'h0005};
        reg_settings[4] = '{16'($urandom_range(12)), 16'($urandom_range(60)),
                            {14'($urandom), 2'd1}, 16'($urandom)};
        reg_settings[5] = '{16'($urandom_range(12)), 16'($urandom_range(60)),
                            {14'($urandom), 2'd3}, 16'($urandom)};
        reg_settings[6] = '{16'($urandom_range(12)), 16'($urandom_range(60)),
                            {14'($urandom), 2'd3}, 16'($urandom)};
        reg_settings[7] = '{16'($urandom_range(12)), 16'($urandom_range(60)),
                            16'($urandom), 16'($urandom)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].len, directed_rows[i].addr,
                         directed_rows[i].typed, directed_rows[i].want);
        drain_pending();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_modes[phase];
            recv_stall_pct = recv_modes[phase];
            for (int half = 0; half < 2; half++) begin
                apply_settings(reg_settings[phase * 2 + half]);
                repeat (PHASE_ITEMS) begin
                    send_random_request();
                    if ($urandom_range(99) == 0) drain_pending();
                end
                drain_pending();
            end
        end

        repeat (30) @(posedge i_clk);
        $display("%0d requests, %0d results over %0d register settings and four idling modes",
                 requests_sent, results_seen, settings_used);
        $display("deauth alerts %0d, beacon alerts %0d, untracked sources %0d, signature hits %0d",
                 deauth_alerts, beacon_alerts, untracked_seen, signature_hits);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
